// File: rtl/core/iolt_pkg.sv
`timescale 1ns / 1ps

package iolt_pkg;

   // sizing
   localparam int REGION_DEPTH  = 16;
   localparam int PENDING_DEPTH = 8;
   localparam int INDENT_BITS   = 10;
   localparam int LINE_BITS     = 20;
   localparam int RESULT_CAP    = 18;

   localparam int TOP_W   = $clog2(REGION_DEPTH + 1);
   localparam int RIDX_W  = $clog2(REGION_DEPTH);
   localparam int PCNT_W  = $clog2(PENDING_DEPTH + 1);
   localparam int PSLOT_W = $clog2(PENDING_DEPTH);
   localparam int QCNT_W  = $clog2(RESULT_CAP + 1);
   localparam int QIDX_W  = $clog2(RESULT_CAP);
   localparam int PADDR_W = RIDX_W + PSLOT_W;
   localparam int PMEM_DEPTH = REGION_DEPTH * PENDING_DEPTH;

   typedef logic [6:0] kind_type;
   typedef logic [2:0] region_type;
   typedef logic [2:0] flags_type;
   typedef logic [2:0] err_type;
   typedef logic [2:0] pcode_type;
   typedef logic [1:0] wclass_type;

   localparam kind_type K_EOF        = 7'd0;
   localparam kind_type K_ERROR      = 7'd1;
   localparam kind_type K_IDENT      = 7'd2;
   localparam kind_type K_INT        = 7'd3;
   localparam kind_type K_FLOAT      = 7'd4;
   localparam kind_type K_CHAR       = 7'd5;
   localparam kind_type K_STRING     = 7'd6;
   localparam kind_type K_ISTRING    = 7'd7;
   localparam kind_type K_THIS       = 7'd8;
   localparam kind_type K_NULL       = 7'd9;
   localparam kind_type K_TRUE       = 7'd10;
   localparam kind_type K_FALSE      = 7'd11;
   localparam kind_type K_RETURN     = 7'd12;
   localparam kind_type K_TYPE       = 7'd13;
   localparam kind_type K_UNDERSCORE = 7'd14;
   localparam kind_type K_GIVEN      = 7'd15;
   localparam kind_type K_NEW        = 7'd16;
   localparam kind_type K_VAL        = 7'd17;
   localparam kind_type K_IF         = 7'd18;
   localparam kind_type K_THEN       = 7'd19;
   localparam kind_type K_ELSE       = 7'd20;
   localparam kind_type K_WHILE      = 7'd21;
   localparam kind_type K_DO         = 7'd22;
   localparam kind_type K_FOR        = 7'd23;
   localparam kind_type K_YIELD      = 7'd24;
   localparam kind_type K_TRY        = 7'd25;
   localparam kind_type K_CATCH      = 7'd26;
   localparam kind_type K_FINALLY    = 7'd27;
   localparam kind_type K_THROW      = 7'd28;
   localparam kind_type K_MATCH      = 7'd29;
   localparam kind_type K_WITH       = 7'd30;
   localparam kind_type K_EXTENDS    = 7'd31;
   localparam kind_type K_LPAREN     = 7'd32;
   localparam kind_type K_RPAREN     = 7'd33;
   localparam kind_type K_LBRACKET   = 7'd34;
   localparam kind_type K_RBRACKET   = 7'd35;
   localparam kind_type K_LBRACE     = 7'd36;
   localparam kind_type K_RBRACE     = 7'd37;
   localparam kind_type K_COMMA      = 7'd38;
   localparam kind_type K_DOT        = 7'd39;
   localparam kind_type K_SEMI       = 7'd40;
   localparam kind_type K_COLON      = 7'd41;
   localparam kind_type K_COLON_EOL  = 7'd42;
   localparam kind_type K_EQUALS     = 7'd43;
   localparam kind_type K_ARROW      = 7'd44;
   localparam kind_type K_CTX_ARROW  = 7'd45;
   localparam kind_type K_TL_ARROW   = 7'd46;
   localparam kind_type K_LEFT_ARROW = 7'd47;
   localparam kind_type K_SUBTYPE    = 7'd48;
   localparam kind_type K_SUPERTYPE  = 7'd49;
   localparam kind_type K_HASH       = 7'd50;
   localparam kind_type K_INDENT     = 7'd51;
   localparam kind_type K_OUTDENT    = 7'd52;
   localparam kind_type K_NEWLINE    = 7'd53;
   localparam kind_type K_END_MARKER = 7'd54;

   localparam region_type R_TOP      = 3'd0;
   localparam region_type R_BRACES   = 3'd1;
   localparam region_type R_PARENS   = 3'd2;
   localparam region_type R_BRACKETS = 3'd3;
   localparam region_type R_INDENTED = 3'd4;

   localparam flags_type F_NONE  = 3'b000;
   localparam flags_type F_KNOWN = 3'b001;
   localparam flags_type F_COND  = 3'b010;
   localparam flags_type F_PROV  = 3'b100;

   localparam err_type E_NONE       = 3'd0;
   localparam err_type E_LEXER      = 3'd1;
   localparam err_type E_UNCLOSED   = 3'd2;
   localparam err_type E_UNBALANCED = 3'd3;
   localparam err_type E_DEDENT     = 3'd4;
   localparam err_type E_UNINDENT   = 3'd5;
   localparam err_type E_OVERFLOW   = 3'd6;

   localparam pcode_type P_NONE  = 3'd0;
   localparam pcode_type P_IF    = 3'd1;
   localparam pcode_type P_THEN  = 3'd2;
   localparam pcode_type P_TRY   = 3'd3;
   localparam pcode_type P_CATCH = 3'd4;
   localparam pcode_type P_WHILE = 3'd5;
   localparam pcode_type P_FOR   = 3'd6;
   localparam pcode_type P_OTHER = 3'd7;

   localparam wclass_type WC_END = 2'd1;
   localparam wclass_type WC_EXT = 2'd2;

   typedef struct packed {
      kind_type               token_kind;
      logic [INDENT_BITS-1:0] line_indent;
      logic                   first_on_line;
      logic                   past_blank_line;
      logic                   plain_operator;
      wclass_type             word_class;
      logic [LINE_BITS-1:0]   line_number;
      kind_type               next_kind;
      logic                   next_first_on_line;
      logic                   blank_after;
      logic                   after_next_ends;
   } req_type;

   typedef struct packed {
      kind_type out_kind;
      logic     synthesized;
      err_type  error_code;
      logic     last;
   } rsp_type;

   typedef struct packed {
      logic                   load;
      logic                   init_top;
      logic                   clr_skip;
      logic                   set_skip;
      logic                   wr_width;
      logic                   wr_flags;
      flags_type              flags_val;
      logic                   push;
      region_type             push_kind;
      logic [INDENT_BITS-1:0] push_width;
      flags_type              push_flags;
      kind_type               push_opener;
      logic                   pop;
      logic                   emit;
      kind_type               emit_kind;
      logic                   emit_synth;
      logic                   set_popped;
      logic                   set_second;
      logic                   idx_load;
      logic                   idx_dec;
      logic                   pend_rd;
      logic [PSLOT_W-1:0]     pend_rd_slot;
      logic                   pend_wr;
      logic [PSLOT_W-1:0]     pend_wr_slot;
      pcode_type              pend_val;
      logic                   pcnt_wr;
      logic [PCNT_W-1:0]      pcnt_val;
      logic                   set_cc;
      logic                   ext_clr;
      logic                   ext_set;
      logic                   set_prev;
      kind_type               prev_val;
      logic                   prev_cc_val;
      logic                   fail;
      err_type                fail_code;
      logic                   clear_all;
      logic                   q_next;
   } cmd_type;

   typedef struct packed {
      req_type                item;
      region_type             top_kind;
      logic [INDENT_BITS-1:0] top_width;
      flags_type              top_flags;
      kind_type               top_opener;
      logic [PCNT_W-1:0]      top_pcnt;
      logic                   top_gt1;
      logic                   top_full;
      kind_type               prev_kind;
      logic                   pcc;
      logic                   ext_hit;
      logic                   seen;
      logic                   halted;
      logic                   skip;
      logic [PCNT_W-1:0]      idx;
      pcode_type              pend_data;
      logic                   second;
      logic                   popped;
      logic                   cc;
      logic                   err;
      logic                   q_empty;
      logic                   q_last;
   } status_type;

   function automatic logic can_end(kind_type k);
      case (k)
         K_INT, K_FLOAT, K_CHAR, K_STRING, K_ISTRING, K_IDENT, K_THIS, K_NULL,
         K_TRUE, K_FALSE, K_RETURN, K_TYPE, K_UNDERSCORE, K_RPAREN, K_RBRACKET,
         K_RBRACE, K_END_MARKER, K_OUTDENT, K_GIVEN: can_end = 1'b1;
         default: can_end = 1'b0;
      endcase
   endfunction

   function automatic logic can_begin(kind_type k);
      case (k)
         K_CATCH, K_ELSE, K_EXTENDS, K_FINALLY, K_MATCH, K_WITH, K_YIELD, K_THEN,
         K_DO, K_COMMA, K_DOT, K_SEMI, K_COLON, K_COLON_EOL, K_EQUALS, K_ARROW,
         K_CTX_ARROW, K_TL_ARROW, K_LEFT_ARROW, K_SUBTYPE, K_SUPERTYPE, K_HASH,
         K_LBRACKET, K_RPAREN, K_RBRACKET, K_RBRACE, K_EOF: can_begin = 1'b0;
         default: can_begin = 1'b1;
      endcase
   endfunction

   function automatic logic opens_region(kind_type k);
      case (k)
         K_EQUALS, K_ARROW, K_CTX_ARROW, K_LEFT_ARROW, K_CATCH, K_DO, K_ELSE,
         K_FINALLY, K_FOR, K_IF, K_MATCH, K_RETURN, K_THEN, K_THROW, K_TRY,
         K_WHILE, K_YIELD, K_WITH, K_COLON_EOL: opens_region = 1'b1;
         default: opens_region = 1'b0;
      endcase
   endfunction

   function automatic logic continues(kind_type k);
      case (k)
         K_THEN, K_ELSE, K_DO, K_CATCH, K_FINALLY, K_YIELD, K_MATCH: continues = 1'b1;
         default: continues = 1'b0;
      endcase
   endfunction

   // keywords that may close a pending partner
   function automatic logic is_kw_closer(kind_type k);
      case (k)
         K_THEN, K_ELSE, K_DO, K_YIELD, K_CATCH, K_FINALLY: is_kw_closer = 1'b1;
         default: is_kw_closer = 1'b0;
      endcase
   endfunction

   function automatic logic partners(kind_type closer, kind_type opener);
      case (closer)
         K_THEN:    partners = (opener == K_IF) || (opener == K_RPAREN);
         K_ELSE:    partners = (opener == K_THEN) || (opener == K_RPAREN);
         K_DO:      partners = (opener == K_WHILE) || (opener == K_FOR) ||
                               (opener == K_RPAREN);
         K_YIELD:   partners = (opener == K_FOR) || (opener == K_RPAREN) ||
                               (opener == K_RBRACE);
         K_CATCH:   partners = (opener == K_TRY);
         K_FINALLY: partners = (opener == K_TRY) || (opener == K_CATCH);
         default:   partners = 1'b0;
      endcase
   endfunction

   function automatic logic is_closer(kind_type k);
      is_closer = (k == K_RPAREN) || (k == K_RBRACKET) || (k == K_RBRACE);
   endfunction

   function automatic logic is_designator(kind_type k);
      case (k)
         K_IDENT, K_IF, K_WHILE, K_FOR, K_MATCH, K_TRY, K_NEW, K_THIS, K_VAL,
         K_GIVEN: is_designator = 1'b1;
         default: is_designator = 1'b0;
      endcase
   endfunction

   function automatic logic is_cond_kw(kind_type k);
      is_cond_kw = (k == K_IF) || (k == K_WHILE) || (k == K_FOR);
   endfunction

   function automatic pcode_type partner_code(kind_type k);
      case (k)
         K_IF:    partner_code = P_IF;
         K_THEN:  partner_code = P_THEN;
         K_TRY:   partner_code = P_TRY;
         K_CATCH: partner_code = P_CATCH;
         K_WHILE: partner_code = P_WHILE;
         K_FOR:   partner_code = P_FOR;
         default: partner_code = P_OTHER;
      endcase
   endfunction

   function automatic kind_type partner_kind(pcode_type c);
      case (c)
         P_IF:    partner_kind = K_IF;
         P_THEN:  partner_kind = K_THEN;
         P_TRY:   partner_kind = K_TRY;
         P_CATCH: partner_kind = K_CATCH;
         P_WHILE: partner_kind = K_WHILE;
         P_FOR:   partner_kind = K_FOR;
         P_OTHER: partner_kind = K_RPAREN;
         default: partner_kind = K_EOF;
      endcase
   endfunction

   function automatic region_type closer_region(kind_type k);
      case (k)
         K_RPAREN:   closer_region = R_PARENS;
         K_RBRACKET: closer_region = R_BRACKETS;
         default:    closer_region = R_BRACES;
      endcase
   endfunction

endpackage

// File: rtl/core/indentation_layout_token_inserter.sv
`timescale 1ns / 1ps

// Offside-rule layout stage. Takes one lexer token per request beat, with its
// one- and two-token lookahead already folded into the beat, and returns the
// inserted indent, outdent and newline tokens followed by the token itself
// (colons at end of line retyped, end markers formed, the designator after an
// end marker swallowed). The last response beat of a token carries last=1; a
// token may give no beat at all. Errors give a single beat with error_code set
// and the block then drops every token until reset; an end-of-file token that
// closes cleanly returns the block to its reset state for a new stream.
// One token is in flight at a time. A plain token that is not first on its
// line and gives one response beat passes through the accepting cycle, four
// control steps and the response beat before the next token is accepted. A
// token first on its line adds the line-break check (only its first step when
// the top region is a bracket), and a dedent adds a pop step per outdent and
// a final check. then/else/do/yield/catch/finally add a search of the
// pending-keyword entries, one per read (the pending store has one registered
// read port), and the same again after popping an indented region they close.
// A closing bracket adds a pop step per outdent and a balance check, and a
// pending-entry read and write when it closes a condition. Further response
// beats follow from the result queue and a stalled response holds the block.
// A swallowed designator or any token after an error stops at the start step.

module indentation_layout_token_inserter import iolt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type st;

   // sequencer: walks one token through line break, keyword and bracket steps
   iolt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // region stack, pending store, result queue
   iolt_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .st       (st),
      .rsp_data (rsp_data)
   );

endmodule

// File: rtl/core/iolt_dpath.sv
`timescale 1ns / 1ps

module iolt_dpath import iolt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type st,
   output rsp_type    rsp_data
);

   typedef struct packed {
      kind_type kind;
      logic     synth;
   } qent_type;

   // region stack, no reset: only entries below the top are read
   region_type             rkind_ff   [REGION_DEPTH];
   logic [INDENT_BITS-1:0] rwidth_ff  [REGION_DEPTH];
   flags_type              rflags_ff  [REGION_DEPTH];
   kind_type               ropener_ff [REGION_DEPTH];
   logic [PCNT_W-1:0]      pcnt_ff    [REGION_DEPTH];
   pcode_type              pend_mem   [PMEM_DEPTH];
   pcode_type              pend_rd_ff;
   qent_type               q_mem      [RESULT_CAP];

   req_type              item_ff, item_in;
   logic [TOP_W-1:0]     top_ff, top_in;
   kind_type             prev_ff, prev_in;
   logic                 pcc_ff, pcc_in;
   logic                 ext_valid_ff, ext_valid_in;
   logic [LINE_BITS-1:0] ext_line_ff, ext_line_in;
   logic                 skip_ff, skip_in;
   logic                 seen_ff, seen_in;
   logic                 halted_ff, halted_in;
   logic [PCNT_W-1:0]    idx_ff, idx_in;
   logic                 second_ff, second_in;
   logic                 popped_ff, popped_in;
   logic                 cc_ff, cc_in;
   err_type              err_ff, err_in;
   logic [QCNT_W-1:0]    q_cnt_ff, q_cnt_in;
   logic [QIDX_W-1:0]    q_rd_ff, q_rd_in;

   logic [RIDX_W-1:0]    tix;
   logic [RIDX_W-1:0]    wix;
   logic [PSLOT_W-1:0]   pwr_slot;
   qent_type             q_head;

   assign tix = top_ff[RIDX_W-1:0] - RIDX_W'(1);
   assign wix = cmd.init_top ? '0 : top_ff[RIDX_W-1:0];
   assign pwr_slot = cmd.pend_wr_slot;

   always_comb begin
      item_in      = item_ff;
      top_in       = top_ff;
      prev_in      = prev_ff;
      pcc_in       = pcc_ff;
      ext_valid_in = ext_valid_ff;
      ext_line_in  = ext_line_ff;
      skip_in      = skip_ff;
      seen_in      = seen_ff;
      halted_in    = halted_ff;
      idx_in       = idx_ff;
      second_in    = second_ff;
      popped_in    = popped_ff;
      cc_in        = cc_ff;
      err_in       = err_ff;
      q_cnt_in     = q_cnt_ff;
      q_rd_in      = q_rd_ff;

      if (cmd.load) begin
         item_in   = req_data;
         err_in    = E_NONE;
         popped_in = 1'b0;
         cc_in     = 1'b0;
         second_in = 1'b0;
         q_cnt_in  = '0;
         q_rd_in   = '0;
      end
      if (cmd.init_top) begin
         top_in  = TOP_W'(1);
         seen_in = 1'b1;
      end else if (cmd.push) begin
         top_in = top_ff + TOP_W'(1);
      end else if (cmd.pop) begin
         top_in = top_ff - TOP_W'(1);
      end
      if (cmd.clr_skip)   skip_in   = 1'b0;
      if (cmd.set_skip)   skip_in   = 1'b1;
      if (cmd.set_popped) popped_in = 1'b1;
      if (cmd.set_second) second_in = 1'b1;
      if (cmd.set_cc)     cc_in     = 1'b1;
      if (cmd.idx_load)   idx_in    = pcnt_ff[tix];
      if (cmd.idx_dec)    idx_in    = idx_ff - PCNT_W'(1);
      if (cmd.ext_clr)    ext_valid_in = 1'b0;
      if (cmd.ext_set) begin
         ext_valid_in = 1'b1;
         ext_line_in  = item_ff.line_number;
      end
      if (cmd.set_prev) begin
         prev_in = cmd.prev_val;
         pcc_in  = cmd.prev_cc_val;
      end
      if (cmd.emit && (q_cnt_ff < QCNT_W'(RESULT_CAP))) q_cnt_in = q_cnt_ff + QCNT_W'(1);
      if (cmd.q_next) q_rd_in = q_rd_ff + QIDX_W'(1);
      if (cmd.clear_all) begin
         top_in       = '0;
         prev_in      = K_EOF;
         pcc_in       = 1'b0;
         ext_valid_in = 1'b0;
         skip_in      = 1'b0;
         seen_in      = 1'b0;
         halted_in    = 1'b0;
      end
      if (cmd.fail) begin
         err_in    = cmd.fail_code;
         halted_in = 1'b1;
         skip_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         prev_ff      <= K_EOF;
         pcc_ff       <= 1'b0;
         ext_valid_ff <= 1'b0;
         skip_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         halted_ff    <= 1'b0;
         err_ff       <= E_NONE;
         q_cnt_ff     <= '0;
         q_rd_ff      <= '0;
         popped_ff    <= 1'b0;
         second_ff    <= 1'b0;
         cc_ff        <= 1'b0;
         idx_ff       <= '0;
      end else begin
         top_ff       <= top_in;
         prev_ff      <= prev_in;
         pcc_ff       <= pcc_in;
         ext_valid_ff <= ext_valid_in;
         skip_ff      <= skip_in;
         seen_ff      <= seen_in;
         halted_ff    <= halted_in;
         err_ff       <= err_in;
         q_cnt_ff     <= q_cnt_in;
         q_rd_ff      <= q_rd_in;
         popped_ff    <= popped_in;
         second_ff    <= second_in;
         cc_ff        <= cc_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      ext_line_ff <= ext_line_in;
   end

   // region stack writes
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rkind_ff[wix]   <= cmd.push_kind;
         rwidth_ff[wix]  <= cmd.push_width;
         rflags_ff[wix]  <= cmd.push_flags;
         ropener_ff[wix] <= cmd.push_opener;
         pcnt_ff[wix]    <= '0;
      end
      if (cmd.wr_width) rwidth_ff[tix] <= item_ff.line_indent;
      if (cmd.wr_flags) rflags_ff[tix] <= cmd.flags_val;
      if (cmd.pcnt_wr)  pcnt_ff[tix]   <= cmd.pcnt_val;
   end

   // pending partner store, one port each way, registered read
   always_ff @(posedge clock) begin
      if (cmd.pend_wr) pend_mem[{tix, pwr_slot}] <= cmd.pend_val;
      if (cmd.pend_rd) pend_rd_ff <= pend_mem[{tix, cmd.pend_rd_slot}];
   end

   // result queue for one input beat
   always_ff @(posedge clock) begin
      if (cmd.emit && (q_cnt_ff < QCNT_W'(RESULT_CAP))) begin
         q_mem[q_cnt_ff[QIDX_W-1:0]] <= '{kind: cmd.emit_kind, synth: cmd.emit_synth};
      end
   end

   assign q_head = q_mem[q_rd_ff];

   always_comb begin
      if (err_ff != E_NONE) begin
         rsp_data = '{out_kind: K_EOF, synthesized: 1'b0, error_code: err_ff, last: 1'b1};
      end else begin
         rsp_data = '{out_kind: q_head.kind, synthesized: q_head.synth,
                      error_code: E_NONE, last: st.q_last};
      end
   end

   assign st.item       = item_ff;
   assign st.top_kind   = rkind_ff[tix];
   assign st.top_width  = rwidth_ff[tix];
   assign st.top_flags  = rflags_ff[tix];
   assign st.top_opener = ropener_ff[tix];
   assign st.top_pcnt   = pcnt_ff[tix];
   assign st.top_gt1    = top_ff > TOP_W'(1);
   assign st.top_full   = top_ff >= TOP_W'(REGION_DEPTH);
   assign st.prev_kind  = prev_ff;
   assign st.pcc        = pcc_ff;
   assign st.ext_hit    = ext_valid_ff && (item_ff.line_number == ext_line_ff);
   assign st.seen       = seen_ff;
   assign st.halted     = halted_ff;
   assign st.skip       = skip_ff;
   assign st.idx        = idx_ff;
   assign st.pend_data  = pend_rd_ff;
   assign st.second     = second_ff;
   assign st.popped     = popped_ff;
   assign st.cc         = cc_ff;
   assign st.err        = err_ff != E_NONE;
   assign st.q_empty    = q_cnt_ff == '0;
   assign st.q_last     = QCNT_W'(q_rd_ff) == (q_cnt_ff - QCNT_W'(1));

endmodule

// File: rtl/core/iolt_ctrl.sv
`timescale 1ns / 1ps

module iolt_ctrl import iolt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type st,
   output cmd_type    cmd
);

   typedef enum logic [19:0] {
      ST_IDLE    = 20'h00001,
      ST_START   = 20'h00002,
      ST_LB_UPD  = 20'h00004,
      ST_LB_DEC  = 20'h00008,
      ST_LB_POP  = 20'h00010,
      ST_LB_FIN  = 20'h00020,
      ST_BODY    = 20'h00040,
      ST_SAT_LD  = 20'h00080,
      ST_SAT_RD  = 20'h00100,
      ST_SAT_CHK = 20'h00200,
      ST_KW_POP  = 20'h00400,
      ST_KIND    = 20'h00800,
      ST_CB_POP  = 20'h01000,
      ST_CB_CHK  = 20'h02000,
      ST_CC_RD   = 20'h04000,
      ST_CC_WR   = 20'h08000,
      ST_FIN     = 20'h10000,
      ST_EOF_POP = 20'h20000,
      ST_EOF_FIN = 20'h40000,
      ST_OUT     = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   kind_type               kind, nk, pend_kind, outk;
   logic [INDENT_BITS-1:0] w;
   logic                   first, next_first;
   logic                   cond_opener, opener_go, w_gt, w_lt, w_eq;
   logic                   lead_inf, end_mark, bracket_top, ind_pop, nl_ok;
   logic                   between, below_top, width_ok, ext_new;

   assign kind       = st.item.token_kind;
   assign nk         = st.item.next_kind;
   assign w          = st.item.line_indent;
   assign first      = st.item.first_on_line;
   assign next_first = st.item.next_first_on_line;
   assign pend_kind  = partner_kind(st.pend_data);

   assign cond_opener = st.pcc && (kind != K_THEN) && (kind != K_DO) && (kind != K_YIELD);
   assign opener_go   = opens_region(st.prev_kind) || cond_opener;
   assign w_gt        = w > st.top_width;
   assign w_lt        = w < st.top_width;
   assign w_eq        = w == st.top_width;
   assign nl_ok       = can_end(st.prev_kind) && can_begin(kind);
   assign bracket_top = (st.top_kind == R_PARENS) || (st.top_kind == R_BRACKETS);
   assign ind_pop     = (st.top_kind == R_INDENTED) && st.top_gt1;

   // operator at line start that continues the previous line
   assign lead_inf = (kind == K_IDENT) && st.item.plain_operator &&
                     !st.item.past_blank_line && (nk != K_EOF) && !next_first &&
                     st.item.blank_after && can_begin(nk) && !is_closer(nk);

   assign end_mark = (kind == K_IDENT) && (st.item.word_class == WC_END) && first &&
                     !next_first && is_designator(nk) && st.item.after_next_ends;

   assign between   = st.popped && (st.top_kind == R_INDENTED) && w_gt;
   assign below_top = (st.top_kind == R_TOP) && !w_eq;
   assign width_ok  = w_eq || ((st.top_kind == R_BRACES) && w_lt);
   assign ext_new   = (kind == K_IDENT) && first && (st.item.word_class == WC_EXT) &&
                      ((nk == K_LPAREN) || (nk == K_LBRACKET));
   assign outk      = ((kind == K_COLON) && next_first) ? K_COLON_EOL : kind;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (st.halted) begin
               state_in = ST_IDLE;
            end else if (st.skip) begin
               cmd.clr_skip = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               if (!st.seen) begin
                  cmd.init_top    = 1'b1;
                  cmd.push        = 1'b1;
                  cmd.push_kind   = R_TOP;
                  cmd.push_width  = w;
                  cmd.push_flags  = F_KNOWN;
                  cmd.push_opener = K_EOF;
               end
               if (kind == K_ERROR) begin
                  cmd.fail      = 1'b1;
                  cmd.fail_code = E_LEXER;
                  state_in      = ST_OUT;
               end else if (kind == K_EOF) begin
                  state_in = ST_EOF_POP;
               end else if (first && st.seen) begin
                  state_in = ST_LB_UPD;
               end else begin
                  state_in = ST_BODY;
               end
            end
         end
         ST_LB_UPD: begin
            if (bracket_top) begin
               state_in = ST_BODY;
            end else begin
               if ((st.top_kind == R_BRACES) && ((st.top_flags & F_KNOWN) == F_NONE)) begin
                  cmd.wr_width  = 1'b1;
                  cmd.wr_flags  = 1'b1;
                  cmd.flags_val = st.top_flags | F_KNOWN;
               end else if ((st.top_flags & F_PROV) != F_NONE) begin
                  cmd.wr_flags  = 1'b1;
                  cmd.flags_val = st.top_flags & ~F_PROV;
                  if (w_gt && !opens_region(st.prev_kind) && !cond_opener) cmd.wr_width = 1'b1;
               end
               state_in = ST_LB_DEC;
            end
         end
         ST_LB_DEC: begin
            if (opener_go && w_gt) begin
               if (st.top_full) begin
                  cmd.fail      = 1'b1;
                  cmd.fail_code = E_OVERFLOW;
                  state_in      = ST_OUT;
               end else begin
                  cmd.push        = 1'b1;
                  cmd.push_kind   = R_INDENTED;
                  cmd.push_width  = w;
                  cmd.push_flags  = F_KNOWN;
                  cmd.push_opener = cond_opener ? K_RPAREN : st.prev_kind;
                  cmd.emit        = 1'b1;
                  cmd.emit_kind   = K_INDENT;
                  cmd.emit_synth  = 1'b1;
                  state_in        = ST_BODY;
               end
            end else if (w_lt) begin
               if (continues(st.prev_kind)) begin
                  cmd.fail      = 1'b1;
                  cmd.fail_code = E_DEDENT;
                  state_in      = ST_OUT;
               end else begin
                  state_in = ST_LB_POP;
               end
            end else begin
               if ((w_eq && nl_ok && !lead_inf) ||
                   (w_gt && st.item.past_blank_line && nl_ok)) begin
                  cmd.emit       = 1'b1;
                  cmd.emit_kind  = K_NEWLINE;
                  cmd.emit_synth = 1'b1;
                  cmd.pcnt_wr    = 1'b1;
               end
               state_in = ST_BODY;
            end
         end
         ST_LB_POP: begin
            if (ind_pop && w_lt) begin
               cmd.pop        = 1'b1;
               cmd.emit       = 1'b1;
               cmd.emit_kind  = K_OUTDENT;
               cmd.emit_synth = 1'b1;
               cmd.set_popped = 1'b1;
            end else begin
               state_in = ST_LB_FIN;
            end
         end
         ST_LB_FIN: begin
            if ((between || below_top) && !is_closer(kind)) begin
               cmd.fail      = 1'b1;
               cmd.fail_code = E_UNINDENT;
               state_in      = ST_OUT;
            end else begin
               if (width_ok && (st.popped || can_end(st.prev_kind)) && can_begin(kind) &&
                   !lead_inf) begin
                  cmd.emit       = 1'b1;
                  cmd.emit_kind  = K_NEWLINE;
                  cmd.emit_synth = 1'b1;
                  cmd.pcnt_wr    = 1'b1;
               end
               state_in = ST_BODY;
            end
         end
         ST_BODY: begin
            if (end_mark) begin
               cmd.emit        = 1'b1;
               cmd.emit_kind   = K_END_MARKER;
               cmd.set_prev    = 1'b1;
               cmd.prev_val    = K_END_MARKER;
               cmd.prev_cc_val = 1'b0;
               cmd.set_skip    = 1'b1;
               state_in        = ST_OUT;
            end else if (is_kw_closer(kind)) begin
               state_in = ST_SAT_LD;
            end else begin
               state_in = ST_KIND;
            end
         end
         ST_SAT_LD: begin
            cmd.idx_load = 1'b1;
            state_in     = ST_SAT_RD;
         end
         ST_SAT_RD: begin
            if (st.idx == '0) begin
               if (!st.second && !first && ind_pop && partners(kind, st.top_opener)) begin
                  state_in = ST_KW_POP;
               end else begin
                  state_in = ST_KIND;
               end
            end else begin
               cmd.pend_rd      = 1'b1;
               cmd.pend_rd_slot = PSLOT_W'(st.idx - PCNT_W'(1));
               cmd.idx_dec      = 1'b1;
               state_in         = ST_SAT_CHK;
            end
         end
         ST_SAT_CHK: begin
            if (partners(kind, pend_kind)) begin
               cmd.pcnt_wr = 1'b1;
               if ((kind == K_THEN) || (kind == K_CATCH)) begin
                  cmd.pend_wr      = 1'b1;
                  cmd.pend_wr_slot = st.idx[PSLOT_W-1:0];
                  cmd.pend_val     = partner_code(kind);
                  cmd.pcnt_val     = st.idx + PCNT_W'(1);
               end else begin
                  cmd.pcnt_val = st.idx;
               end
               state_in = ST_KIND;
            end else begin
               state_in = ST_SAT_RD;
            end
         end
         ST_KW_POP: begin
            cmd.pop        = 1'b1;
            cmd.emit       = 1'b1;
            cmd.emit_kind  = K_OUTDENT;
            cmd.emit_synth = 1'b1;
            cmd.set_second = 1'b1;
            state_in       = ST_SAT_LD;
         end
         ST_KIND: begin
            case (kind)
               K_LPAREN, K_LBRACKET, K_LBRACE: begin
                  if (st.top_full) begin
                     cmd.fail      = 1'b1;
                     cmd.fail_code = E_OVERFLOW;
                     state_in      = ST_OUT;
                  end else begin
                     cmd.push        = 1'b1;
                     cmd.push_opener = K_EOF;
                     if (kind == K_LPAREN) begin
                        cmd.push_kind  = R_PARENS;
                        cmd.push_width = '0;
                        cmd.push_flags = F_KNOWN |
                                         (is_cond_kw(st.prev_kind) ? F_COND : F_NONE);
                     end else if (kind == K_LBRACKET) begin
                        cmd.push_kind  = R_BRACKETS;
                        cmd.push_width = '0;
                        cmd.push_flags = F_KNOWN;
                     end else begin
                        cmd.push_kind  = R_BRACES;
                        cmd.push_width = next_first ? '0 : w;
                        cmd.push_flags = (next_first ? F_NONE : (F_KNOWN | F_PROV)) |
                                         ((st.prev_kind == K_FOR) ? F_COND : F_NONE);
                     end
                     state_in = ST_FIN;
                  end
               end
               K_RPAREN, K_RBRACKET, K_RBRACE: begin
                  state_in = ST_CB_POP;
               end
               K_SEMI: begin
                  cmd.pcnt_wr = 1'b1;
                  state_in    = ST_FIN;
               end
               K_IF, K_TRY, K_WHILE, K_FOR: begin
                  if (st.top_pcnt >= PCNT_W'(PENDING_DEPTH)) begin
                     cmd.fail      = 1'b1;
                     cmd.fail_code = E_OVERFLOW;
                     state_in      = ST_OUT;
                  end else begin
                     cmd.pend_wr      = 1'b1;
                     cmd.pend_wr_slot = st.top_pcnt[PSLOT_W-1:0];
                     cmd.pend_val     = partner_code(kind);
                     cmd.pcnt_wr      = 1'b1;
                     cmd.pcnt_val     = st.top_pcnt + PCNT_W'(1);
                     state_in         = ST_FIN;
                  end
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_CB_POP: begin
            if (ind_pop) begin
               cmd.pop        = 1'b1;
               cmd.emit       = 1'b1;
               cmd.emit_kind  = K_OUTDENT;
               cmd.emit_synth = 1'b1;
            end else begin
               state_in = ST_CB_CHK;
            end
         end
         ST_CB_CHK: begin
            if ((st.top_kind != closer_region(kind)) || !st.top_gt1) begin
               cmd.fail      = 1'b1;
               cmd.fail_code = E_UNBALANCED;
               state_in      = ST_OUT;
            end else begin
               cmd.pop = 1'b1;
               if ((st.top_flags & F_COND) != F_NONE) begin
                  cmd.set_cc = 1'b1;
                  state_in   = ST_CC_RD;
               end else if (st.ext_hit && next_first) begin
                  cmd.set_cc  = 1'b1;
                  cmd.ext_clr = 1'b1;
                  state_in    = ST_CC_RD;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_CC_RD: begin
            if (st.top_pcnt != '0) begin
               cmd.pend_rd      = 1'b1;
               cmd.pend_rd_slot = PSLOT_W'(st.top_pcnt - PCNT_W'(1));
               state_in         = ST_CC_WR;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_CC_WR: begin
            if (is_cond_kw(pend_kind)) begin
               cmd.pend_wr      = 1'b1;
               cmd.pend_wr_slot = PSLOT_W'(st.top_pcnt - PCNT_W'(1));
               cmd.pend_val     = P_OTHER;
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.ext_set     = ext_new;
            cmd.emit        = 1'b1;
            cmd.emit_kind   = outk;
            cmd.set_prev    = 1'b1;
            cmd.prev_val    = outk;
            cmd.prev_cc_val = st.cc;
            state_in        = ST_OUT;
         end
         ST_EOF_POP: begin
            if (ind_pop) begin
               cmd.pop        = 1'b1;
               cmd.emit       = 1'b1;
               cmd.emit_kind  = K_OUTDENT;
               cmd.emit_synth = 1'b1;
            end else begin
               state_in = ST_EOF_FIN;
            end
         end
         ST_EOF_FIN: begin
            if (st.top_gt1) begin
               cmd.fail      = 1'b1;
               cmd.fail_code = E_UNCLOSED;
            end else begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = K_EOF;
               cmd.clear_all = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (st.err) begin
               rsp_valid = 1'b1;
               if (!rsp_stall) state_in = ST_IDLE;
            end else if (st.q_empty) begin
               state_in = ST_IDLE;
            end else begin
               rsp_valid = 1'b1;
               if (!rsp_stall) begin
                  if (st.q_last) state_in = ST_IDLE;
                  else           cmd.q_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule
